/* rtl/mera_pkg.sv */
// Shared types and constants for the mutual exclusion request arbiter.
package mera_pkg;

  localparam int MAX_NODES = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int TIME_W    = 15;
  localparam int ID_W      = 4;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MY_ID      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEER_COUNT = 1'd1;

  typedef enum logic [2:0] {
    KIND_REQ      = 3'd0,
    KIND_PEER_REQ = 3'd1,
    KIND_REPLY    = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_RELEASE  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_REQUEST = 2'd1,
    ACT_REPLY   = 2'd2,
    ACT_ENTER   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ENTER,
    ST_WALK
  } state_t;

endpackage

/* rtl/mutual_exclusion_request_arbiter_top.sv */
// Top level of one Ricart-Agrawala mutual exclusion node.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   kind, peer_id, peer_time, local_time
//   out      output     out_valid/out_stall action, target_id, msg_time, all_done, last
//   cfg      input      cfg_we              cfg_index, cfg_wdata
//
// An item is taken in the idle state and executed in the EXEC state once the
// output register is free. A local request with no peers passes through the
// ENTER state for its second result. A release scans the deferred bits one per
// cycle, holding on a set bit while the output is stalled, and stops after the
// last set bit; with nothing deferred the scan runs over all MAX_NODES bits.
// Every result waits for the single output register to be free; a stall on the
// output channel therefore holds the sequencer, and in_stall stays high until
// the sequencer is back in its idle state.
// Reset (rst_n low, synchronous) clears all node state and the deferred bits,
// and loads my_id = 1, peer_count = 1.
module mutual_exclusion_request_arbiter_top
  import mera_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input item channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_kind,
  input  logic [ID_W-1:0]      in_peer_id,
  input  logic [TIME_W-1:0]    in_peer_time,
  input  logic [TIME_W-1:0]    in_local_time,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_action,
  output logic [ID_W-1:0]      out_target_id,
  output logic [TIME_W-1:0]    out_msg_time,
  output logic                 out_all_done,
  output logic                 out_last,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  // Sequencer.
  state_t state_r, state_nxt;

  // Latched input item.
  kind_t              kind_r;
  logic [ID_W-1:0]    pid_r;
  logic [TIME_W-1:0]  ptime_r;
  logic [TIME_W-1:0]  ltime_r;

  // Configuration registers.
  logic [ID_W-1:0]    my_id_r;
  logic [CNT_W-1:0]   pc_r;

  // Node state.
  logic                 requesting_r, requesting_nxt;
  logic [TIME_W-1:0]    rtime_r, rtime_nxt;
  logic [CNT_W-1:0]     rc_r, rc_nxt;
  logic [CNT_W-1:0]     dc_r, dc_nxt;
  logic [MAX_NODES-1:0] deferred_r, deferred_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  // Output register.
  logic                 out_valid_r;
  action_t              out_action_r;
  logic [ID_W-1:0]      out_target_r;
  logic [TIME_W-1:0]    out_time_r;
  logic                 out_all_done_r;
  logic                 out_last_r;

  // Result produced by the sequencer this cycle.
  logic                 emit;
  action_t              emit_action;
  logic [ID_W-1:0]      emit_target;
  logic [TIME_W-1:0]    emit_time;
  logic                 emit_last;
  logic                 emit_all_done;

  // Shared magnitude comparator, steered by the sequencer.
  logic [TIME_W-1:0]    cmp_a, cmp_b;
  logic                 cmp_lt, cmp_eq;

  logic                 slot_free;
  logic [CNT_W-1:0]     rc_inc, dc_inc, dc_sel;
  logic                 prior, pid_in_range, reply_take, higher_set, walk_end;
  logic [IDX_W-1:0]     pid_idx;
  logic [MAX_NODES-1:0] above;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  assign rc_inc = rc_r + CNT_W'(1);
  assign dc_inc = (dc_r == '1) ? dc_r : dc_r + CNT_W'(1);
  assign dc_sel = (state_r == ST_EXEC && kind_r == KIND_DONE) ? dc_inc : dc_r;

  // The comparator serves the timestamp check of a peer request, the reply
  // count check of a reply and the zero-peer check of a local request.
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (kind_r)
      KIND_PEER_REQ: begin
        cmp_a = rtime_r;
        cmp_b = ptime_r;
      end
      KIND_REPLY: begin
        cmp_a = TIME_W'(rc_inc);
        cmp_b = TIME_W'(pc_r);
      end
      KIND_REQ: begin
        cmp_a = '0;
        cmp_b = TIME_W'(pc_r);
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);

  // Our own pending request wins on an earlier time, or on a tie with a
  // lower id.
  assign prior        = requesting_r && (cmp_lt || (cmp_eq && (my_id_r < pid_r)));
  assign pid_in_range = (32'(pid_r) < 32'(MAX_NODES));
  assign pid_idx      = IDX_W'(pid_r);
  assign reply_take   = requesting_r && (rc_r < pc_r);

  // Any deferred bit above the current scan position decides the last flag.
  assign above      = (deferred_r >> idx_r) >> 1;
  assign higher_set = |above;
  assign walk_end   = (idx_r == IDX_W'(MAX_NODES - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) begin
          case (kind_r)
            KIND_REQ:     state_nxt = !cmp_lt ? ST_ENTER : ST_IDLE;
            KIND_RELEASE: state_nxt = ST_WALK;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ENTER: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        if (deferred_r[idx_r]) begin
          if (slot_free && (!higher_set || walk_end)) state_nxt = ST_IDLE;
        end else if (walk_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Node state updates and the result to emit.
  always_comb begin
    requesting_nxt = requesting_r;
    rtime_nxt      = rtime_r;
    rc_nxt         = rc_r;
    dc_nxt         = dc_r;
    deferred_nxt   = deferred_r;
    idx_nxt        = idx_r;
    emit           = 1'b0;
    emit_action    = ACT_NONE;
    emit_target    = '0;
    emit_time      = '0;
    emit_last      = 1'b1;
    emit_all_done  = (dc_sel >= pc_r);
    case (state_r)
      ST_EXEC: begin
        if (slot_free) begin
          case (kind_r)
            KIND_REQ: begin
              requesting_nxt = 1'b1;
              rtime_nxt      = ltime_r;
              rc_nxt         = '0;
              emit           = 1'b1;
              emit_action    = ACT_REQUEST;
              emit_time      = ltime_r;
              emit_last      = cmp_lt;
            end
            KIND_PEER_REQ: begin
              if (prior && pid_in_range) begin
                deferred_nxt[pid_idx] = 1'b1;
              end else begin
                emit        = 1'b1;
                emit_action = ACT_REPLY;
                emit_target = pid_r;
                emit_time   = ltime_r;
              end
            end
            KIND_REPLY: begin
              if (reply_take) begin
                rc_nxt = rc_inc;
                if (!cmp_lt) begin
                  emit        = 1'b1;
                  emit_action = ACT_ENTER;
                  emit_time   = rtime_r;
                end
              end
            end
            KIND_DONE: begin
              dc_nxt = dc_inc;
              emit   = 1'b1;
            end
            KIND_RELEASE: begin
              requesting_nxt = 1'b0;
              rc_nxt         = '0;
              idx_nxt        = '0;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      ST_ENTER: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_action = ACT_ENTER;
          emit_time   = rtime_r;
        end
      end
      ST_WALK: begin
        if (deferred_r[idx_r]) begin
          if (slot_free) begin
            deferred_nxt[idx_r] = 1'b0;
            emit        = 1'b1;
            emit_action = ACT_REPLY;
            emit_target = ID_W'(idx_r);
            emit_time   = ltime_r;
            emit_last   = !higher_set;
            idx_nxt     = idx_r + IDX_W'(1);
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control and node state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      requesting_r <= 1'b0;
      rtime_r      <= '0;
      rc_r         <= '0;
      dc_r         <= '0;
      deferred_r   <= '0;
      idx_r        <= '0;
      my_id_r      <= ID_W'(1);
      pc_r         <= CNT_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      requesting_r <= requesting_nxt;
      rtime_r      <= rtime_nxt;
      rc_r         <= rc_nxt;
      dc_r         <= dc_nxt;
      deferred_r   <= deferred_nxt;
      idx_r        <= idx_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MY_ID:      my_id_r <= ID_W'(cfg_wdata);
          REG_PEER_COUNT: pc_r    <= CNT_W'(cfg_wdata);
          default:        my_id_r <= my_id_r;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      kind_r  <= kind_t'(in_kind);
      pid_r   <= in_peer_id;
      ptime_r <= in_peer_time;
      ltime_r <= in_local_time;
    end
    if (emit) begin
      out_action_r   <= emit_action;
      out_target_r   <= emit_target;
      out_time_r     <= emit_time;
      out_all_done_r <= emit_all_done;
      out_last_r     <= emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_action    = out_action_r;
  assign out_target_id = out_target_r;
  assign out_msg_time  = out_time_r;
  assign out_all_done  = out_all_done_r;
  assign out_last      = out_last_r;

endmodule

/* rtl/mera_chk.sv */
// Port-level assertion checker for the arbiter top level, with its bind.
module mera_chk
  import mera_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           out_action,
  input logic [ID_W-1:0]      out_target_id,
  input logic [TIME_W-1:0]    out_msg_time,
  input logic                 out_all_done,
  input logic                 out_last
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_target_id) && $stable(out_msg_time) && $stable(out_all_done) &&
      $stable(out_last))
    else $error("stalled result changed");

  // After taking an item the node reports busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted back to back");

  // A done acknowledgment carries no target or time and ends its item.
  a_none_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_NONE) |->
      (out_target_id == '0) && (out_msg_time == '0) && out_last)
    else $error("malformed done result");

  // Entry and multicast results never name a target.
  a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_action == ACT_ENTER) || (out_action == ACT_REQUEST)) |->
      (out_target_id == '0))
    else $error("target on request or enter");

endmodule

bind mutual_exclusion_request_arbiter_top mera_chk u_mera_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_action    (out_action),
  .out_target_id (out_target_id),
  .out_msg_time  (out_msg_time),
  .out_all_done  (out_all_done),
  .out_last      (out_last)
);

/* test/mera_checker.sv */
// Checker for the mutual exclusion node: predicts each item's results and compares them.
module mera_checker
  import mera_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [2:0]           in_kind,
  input  logic [ID_W-1:0]      in_peer_id,
  input  logic [TIME_W-1:0]    in_peer_time,
  input  logic [TIME_W-1:0]    in_local_time,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_action,
  input  logic [ID_W-1:0]      out_target_id,
  input  logic [TIME_W-1:0]    out_msg_time,
  input  logic                 out_all_done,
  input  logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int                   mismatches,
  output int                   pending,
  output int                   results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    action_t           action;
    logic [ID_W-1:0]   target;
    logic [TIME_W-1:0] msg_time;
    logic              all_done;
    logic              last;
  } node_msg_t;

  // Expected outgoing messages, oldest first.
  node_msg_t expected_msgs[$];

  // Shadow copy of the node's registers and state.
  logic [ID_W-1:0]      node_id;
  logic [CNT_W-1:0]     peers;
  logic                 requesting;
  logic [TIME_W-1:0]    request_time;
  logic [CNT_W-1:0]     replies_seen;
  logic [CNT_W-1:0]     dones_seen;
  logic [MAX_NODES-1:0] deferred_q;

  node_msg_t got;
  node_msg_t want;

  function automatic node_msg_t make_msg(action_t act, logic [ID_W-1:0] tgt,
                                         logic [TIME_W-1:0] t);
    node_msg_t m;
    m.action   = act;
    m.target   = tgt;
    m.msg_time = t;
    m.all_done = (dones_seen >= peers);
    m.last     = 1'b0;
    return m;
  endfunction

  // Advances the shadow node by one item and queues the messages it sends.
  task automatic predict_messages(input logic [2:0] kind, input logic [ID_W-1:0] pid,
                                  input logic [TIME_W-1:0] ptime,
                                  input logic [TIME_W-1:0] ltime);
    node_msg_t batch[$];
    logic      prior;
    case (kind)
      KIND_REQ: begin
        requesting   = 1'b1;
        request_time = ltime;
        replies_seen = '0;
        batch.push_back(make_msg(ACT_REQUEST, '0, ltime));
        if (replies_seen >= peers) batch.push_back(make_msg(ACT_ENTER, '0, request_time));
      end
      KIND_PEER_REQ: begin
        prior = requesting && (request_time < ptime ||
                               (request_time == ptime && node_id < pid));
        if (prior && pid < MAX_NODES) begin
          deferred_q[pid] = 1'b1;
        end else begin
          batch.push_back(make_msg(ACT_REPLY, pid, ltime));
        end
      end
      KIND_REPLY: begin
        if (requesting && replies_seen < peers) begin
          replies_seen = replies_seen + 1'b1;
          if (replies_seen >= peers) batch.push_back(make_msg(ACT_ENTER, '0, request_time));
        end
      end
      KIND_DONE: begin
        if (dones_seen < 4'd15) dones_seen = dones_seen + 1'b1;
        batch.push_back(make_msg(ACT_NONE, '0, '0));
      end
      KIND_RELEASE: begin
        requesting   = 1'b0;
        replies_seen = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
          if (deferred_q[i]) batch.push_back(make_msg(ACT_REPLY, ID_W'(i), ltime));
        end
        deferred_q = '0;
      end
      default: begin
      end
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_msgs.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      node_id         = 4'd1;
      peers           = 4'd1;
      requesting      = 1'b0;
      request_time    = '0;
      replies_seen    = '0;
      dones_seen      = '0;
      deferred_q      = '0;
      expected_msgs.delete();
      mismatches      = 0;
      results_checked = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MY_ID) node_id = cfg_wdata;
        else if (cfg_index == REG_PEER_COUNT) peers = cfg_wdata;
      end
      if (in_valid && !in_stall)
        predict_messages(in_kind, in_peer_id, in_peer_time, in_local_time);
      if (out_valid && !out_stall) begin
        got.action   = action_t'(out_action);
        got.target   = out_target_id;
        got.msg_time = out_msg_time;
        got.all_done = out_all_done;
        got.last     = out_last;
        results_checked++;
        if (expected_msgs.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: action %0d target %0d time %0d all_done %0d last %0d",
                     got.action, got.target, got.msg_time, got.all_done, got.last);
          mismatches++;
        end else begin
          want = expected_msgs.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("result %0d expected: action %0d target %0d time %0d all_done %0d last %0d",
                       results_checked, want.action, want.target, want.msg_time,
                       want.all_done, want.last);
              $display("result %0d actual:   action %0d target %0d time %0d all_done %0d last %0d",
                       results_checked, got.action, got.target, got.msg_time,
                       got.all_done, got.last);
            end
            mismatches++;
          end
        end
      end
    end
    pending = expected_msgs.size();
  end

endmodule

/* test/tb_mutual_exclusion_request_arbiter_top.sv */
// Testbench top for the mutual exclusion node: stimulus, idling, watchdog and verdict.
module tb_mutual_exclusion_request_arbiter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mera_pkg::*;

  // Longest stretch without any accepted item before the run is declared hung.
  // The worst honest stretch is a drain pause plus a sender gap plus a release walk
  // stalled by the receiver, well under this limit.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet time before a register write, so a release walk that sends nothing
  // (or any other silent item) has finished inside the block.
  localparam int DRAIN_PAUSE    = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           in_kind;
  logic [ID_W-1:0]      in_peer_id;
  logic [TIME_W-1:0]    in_peer_time;
  logic [TIME_W-1:0]    in_local_time;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_action;
  logic [ID_W-1:0]      out_target_id;
  logic [TIME_W-1:0]    out_msg_time;
  logic                 out_all_done;
  logic                 out_last;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int results_checked;

  // Idling switches for the two sides; both are turned off for the last phase.
  bit send_idle_on;
  bit recv_idle_on;

  int items_sent;
  int settings_run;
  int quiet_cycles;
  int phase_end;

  // The node's current peer count, so that well-formed rounds fit it.
  logic [CNT_W-1:0] cur_peers;

  logic [ID_W-1:0]  phase_ids[7]   = '{4'd15, 4'd1, 4'd7, 4'd1, 4'd15, 4'd0, 4'd0};
  logic [CNT_W-1:0] phase_peers[7] = '{4'd14, 4'd0, 4'd3, 4'd14, 4'd1, 4'd0, 4'd0};

  mutual_exclusion_request_arbiter_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_peer_id    (in_peer_id),
    .in_peer_time  (in_peer_time),
    .in_local_time (in_local_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_target_id (out_target_id),
    .out_msg_time  (out_msg_time),
    .out_all_done  (out_all_done),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  mera_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_peer_id      (in_peer_id),
    .in_peer_time    (in_peer_time),
    .in_local_time   (in_local_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_target_id   (out_target_id),
    .out_msg_time    (out_msg_time),
    .out_all_done    (out_all_done),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one item and returns at the edge where it is taken. Valid is left high,
  // so back-to-back items never lower and raise it in the same time step; it is
  // only lowered when an idle gap is inserted or the sender goes quiet.
  task automatic send_item(input logic [2:0] kind, input logic [ID_W-1:0] pid,
                           input logic [TIME_W-1:0] ptime, input logic [TIME_W-1:0] ltime);
    int gap;
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_peer_id    <= pid;
    in_peer_time  <= ptime;
    in_local_time <= ltime;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stops sending, waits on falling edges until every expected message has come
  // out, then lets the block settle before anything else happens.
  task automatic drain_node();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Writes both registers, the id first and then the peer count; the node is idle here.
  task automatic set_node(input logic [ID_W-1:0] id, input logic [CNT_W-1:0] peer_num);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MY_ID;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_index <= REG_PEER_COUNT;
    cfg_wdata <= peer_num;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_peers  = peer_num;
    settings_run++;
  endtask

  // Timestamps lean toward both ends of the clock range.
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return TIME_W'($urandom);
    endcase
  endfunction

  // Anything at all, unused kinds included.
  task automatic noise_item();
    send_item(3'($urandom_range(0, 7)), ID_W'($urandom), TIME_W'($urandom),
              TIME_W'($urandom));
  endtask

  // One request cycle of the protocol: request, a mix of replies, competing
  // requests stamped close to ours (so ties and near misses are frequent), done
  // messages and noise, then usually a release that flushes the deferred peers.
  task automatic run_round();
    logic [TIME_W-1:0] stamp;
    int                steps;
    int                pick;
    stamp = pick_time();
    send_item(KIND_REQ, ID_W'($urandom), TIME_W'($urandom), stamp);
    steps = cur_peers + $urandom_range(0, 4);
    repeat (steps) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)
        send_item(KIND_REPLY, ID_W'($urandom), TIME_W'($urandom), pick_time());
      else if (pick < 8)
        send_item(KIND_PEER_REQ, ID_W'($urandom),
                  stamp + TIME_W'($urandom_range(0, 6)) - TIME_W'(3), pick_time());
      else if (pick < 9)
        send_item(KIND_DONE, ID_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
      else
        noise_item();
    end
    if ($urandom_range(0, 5) != 0)
      send_item(KIND_RELEASE, ID_W'($urandom), TIME_W'($urandom), pick_time());
  endtask

  // Receiver: random stall bursts between stretches that take every result at
  // once. Once idling is switched off the stall stays low.
  initial begin
    out_stall = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (recv_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Watchdog: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_REQ;
    in_peer_id    = '0;
    in_peer_time  = '0;
    in_local_time = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_MY_ID;
    cfg_wdata     = '0;
    quiet_cycles  = 0;
    items_sent    = 0;
    settings_run  = 1;
    cur_peers     = 4'd1;
    send_idle_on  = 1'b1;
    recv_idle_on  = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: id 1, one peer.
    // A peer request while idle is answered at once; a stray reply is ignored.
    send_item(KIND_PEER_REQ, 4'd15, '1, '0);
    send_item(KIND_REPLY, 4'd0, '0, '0);
    send_item(KIND_REQ, 4'd0, '0, 15'd100);
    // Later stamp loses and is deferred; the same stamp splits on the id.
    send_item(KIND_PEER_REQ, 4'd2, 15'd200, 15'd101);
    send_item(KIND_PEER_REQ, 4'd0, 15'd100, 15'd102);
    send_item(KIND_PEER_REQ, 4'd3, 15'd100, 15'd103);
    send_item(KIND_PEER_REQ, 4'd1, 15'd50, 15'd104);
    send_item(KIND_DONE, 4'd4, '0, '0);
    // The one reply grants entry; a second one after the grant is ignored.
    send_item(KIND_REPLY, 4'd5, '0, '0);
    send_item(KIND_REPLY, 4'd5, '0, '0);
    // A repeated request restamps and keeps the deferred peers.
    send_item(KIND_REQ, 4'd0, '0, '1);
    send_item(KIND_PEER_REQ, 4'd15, '1, '1);
    send_item(KIND_PEER_REQ, 4'd0, '0, '1);
    // The release replies to peers 2, 3 and 15 in order; a second one sends nothing.
    send_item(KIND_RELEASE, '1, '1, '0);
    send_item(KIND_RELEASE, '0, '0, '1);
    // Kinds past the release code are ignored.
    for (int k = KIND_RELEASE + 1; k < 8; k++) send_item(3'(k), '1, '1, '1);
    drain_node();

    // Highest id with no peers: a request is granted at once, and this node
    // never wins a tie because no id is above it.
    set_node(4'd15, 4'd0);
    send_item(KIND_REQ, '0, '0, '0);
    send_item(KIND_PEER_REQ, 4'd15, '0, 15'd1);
    send_item(KIND_PEER_REQ, 4'd0, 15'd1, 15'd2);
    send_item(KIND_PEER_REQ, 4'd7, '1, 15'd3);
    send_item(KIND_REPLY, 4'd1, '0, '0);
    send_item(KIND_RELEASE, '0, '0, '1);
    drain_node();

    // Random phases, each under its own settings; the last two pick theirs at
    // random and the final one runs with no idling on either side.
    for (int p = 0; p < 7; p++) begin
      if (p >= 5) begin
        phase_ids[p]   = ID_W'($urandom_range(1, 15));
        phase_peers[p] = CNT_W'($urandom_range(0, 14));
      end
      if (p == 6) begin
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
      end
      set_node(phase_ids[p], phase_peers[p]);
      phase_end = items_sent + 30;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) noise_item();
        else run_round();
      end
      drain_node();
    end

    $display("Covered %0d items under %0d node settings; %0d results were checked.",
             items_sent, settings_run, results_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mera_pkg.sv
rtl/mutual_exclusion_request_arbiter_top.sv
rtl/mera_chk.sv
test/mera_checker.sv
test/tb_mutual_exclusion_request_arbiter_top.sv
